FILE: rtl/core/can_bit_timing_search_assert.svh
// Assertion macros shared by the bit timing search modules.
`ifndef CAN_BIT_TIMING_SEARCH_ASSERT_SVH
`define CAN_BIT_TIMING_SEARCH_ASSERT_SVH

`ifndef SYNTH

`define CBTS_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

`define CBTS_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CBTS_ASSERT_IMP(lbl, ck, rstn, ante, cons)

`define CBTS_ASSERT_NXT(lbl, ck, rstn, ante, cons)

`endif

`endif

FILE: rtl/core/cbts_pkg.sv
`timescale 1ns / 1ps

package cbts_pkg;

  localparam int OSC_W   = 26;
  localparam int RATE_W  = 20;
  localparam int TQ_W    = 5;
  localparam int CAND_N  = 8;
  localparam int CAND_IW = 3;
  localparam int QUO_W   = 7;
  localparam int SHIFT_N = QUO_W - 1;
  localparam int DSH_W   = OSC_W + SHIFT_N;
  localparam int STEP_W  = 3;
  localparam int PRE_W   = 6;
  localparam int PH1_W   = 8;
  localparam int PH2_W   = 3;

  localparam logic [OSC_W-1:0]   OSC_RESET = 26'd16000000;
  localparam logic [QUO_W-1:0]   MAX_QUO   = 7'd64;
  localparam logic [PH1_W-1:0]   PS1_MARK  = 8'h80;
  localparam logic [STEP_W-1:0]  STEP_TOP  = 3'(SHIFT_N);
  localparam logic [CAND_IW-1:0] CAND_LAST = 3'(CAND_N - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic load;
    logic calc_div;
    logic div_init;
    logic div_step;
    logic next_cand;
    logic emit_ok;
    logic emit_fail;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic step_last;
    logic fit;
    logic cand_last;
  } sts_t;

  // Time quanta per bit, tried in this order.
  function automatic logic [TQ_W-1:0] tq_of(input logic [CAND_IW-1:0] idx);
    logic [TQ_W-1:0] tq;
    case (idx)
      3'd0: tq = 5'd16;
      3'd1: tq = 5'd12;
      3'd2: tq = 5'd10;
      3'd3: tq = 5'd9;
      3'd4: tq = 5'd8;
      3'd5: tq = 5'd7;
      3'd6: tq = 5'd6;
      default: tq = 5'd5;
    endcase
    return tq;
  endfunction

  function automatic logic [PH1_W-1:0] ph1_of(input logic [CAND_IW-1:0] idx);
    logic [TQ_W-1:0] tq;
    logic [TQ_W-1:0] ps1;
    logic [TQ_W-1:0] ps2;
    logic [TQ_W-1:0] ps1m;
    tq  = tq_of(idx);
    ps1 = (tq - 5'd1) >> 1;
    ps2 = tq - 5'd2 - ps1;
    if (ps2 < 5'd2) begin
      ps1 = tq - 5'd4;
    end
    ps1m = ps1 - 5'd1;
    return PS1_MARK | {ps1m, 3'b000};
  endfunction

  function automatic logic [PH2_W-1:0] ph2_of(input logic [CAND_IW-1:0] idx);
    logic [TQ_W-1:0] tq;
    logic [TQ_W-1:0] ps1;
    logic [TQ_W-1:0] ps2;
    logic [TQ_W-1:0] ps2m;
    tq  = tq_of(idx);
    ps1 = (tq - 5'd1) >> 1;
    ps2 = tq - 5'd2 - ps1;
    if (ps2 < 5'd2) begin
      ps2 = 5'd2;
    end
    ps2m = ps2 - 5'd1;
    return ps2m[PH2_W-1:0];
  endfunction

endpackage

FILE: rtl/core/cbts_ctrl.sv
`timescale 1ns / 1ps

`include "can_bit_timing_search_assert.svh"

module cbts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  cbts_pkg::sts_t sts,
  output cbts_pkg::cmd_t cmd
);

  cbts_pkg::state_t state_r;
  cbts_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbts_pkg::ST_IDLE: begin
        if (start) state_nxt = cbts_pkg::ST_CHECK;
      end
      cbts_pkg::ST_CHECK: begin
        state_nxt = sts.zero ? cbts_pkg::ST_IDLE : cbts_pkg::ST_MUL;
      end
      cbts_pkg::ST_MUL:  state_nxt = cbts_pkg::ST_LOAD;
      cbts_pkg::ST_LOAD: state_nxt = cbts_pkg::ST_DIV;
      cbts_pkg::ST_DIV: begin
        if (sts.step_last) state_nxt = cbts_pkg::ST_EVAL;
      end
      cbts_pkg::ST_EVAL: begin
        if (sts.fit || sts.cand_last) begin
          state_nxt = cbts_pkg::ST_IDLE;
        end else begin
          state_nxt = cbts_pkg::ST_MUL;
        end
      end
      default: state_nxt = cbts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      cbts_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      cbts_pkg::ST_CHECK: cmd.emit_fail = sts.zero;
      cbts_pkg::ST_MUL:   cmd.calc_div  = 1'b1;
      cbts_pkg::ST_LOAD:  cmd.div_init  = 1'b1;
      cbts_pkg::ST_DIV:   cmd.div_step  = 1'b1;
      cbts_pkg::ST_EVAL: begin
        cmd.emit_ok   = sts.fit;
        cmd.emit_fail = !sts.fit && sts.cand_last;
        cmd.next_cand = !sts.fit && !sts.cand_last;
      end
      default: busy = 1'b0;
    endcase
  end

  `CBTS_ASSERT_NXT(a_emit_to_idle, clk, rst_n, cmd.emit_ok || cmd.emit_fail,
                   state_r == cbts_pkg::ST_IDLE)
  `CBTS_ASSERT_IMP(a_emit_excl, clk, rst_n, cmd.emit_ok, !cmd.emit_fail)
  `CBTS_ASSERT_NXT(a_eval_after_div, clk, rst_n,
                   state_r == cbts_pkg::ST_DIV && sts.step_last,
                   state_r == cbts_pkg::ST_EVAL)

endmodule

FILE: rtl/core/cbts_datapath.sv
`timescale 1ns / 1ps

`include "can_bit_timing_search_assert.svh"

module cbts_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cbts_pkg::OSC_W-1:0]    cfg_wr_data,
  input  logic [cbts_pkg::RATE_W-1:0]   in_bit_rate,
  input  cbts_pkg::cmd_t                cmd,
  output cbts_pkg::sts_t                sts,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [cbts_pkg::PRE_W-1:0]    out_prescaler_byte,
  output logic [cbts_pkg::PH1_W-1:0]    out_phase_one_byte,
  output logic [cbts_pkg::PH2_W-1:0]    out_phase_two_byte
);

  localparam int PROD_W = cbts_pkg::RATE_W + cbts_pkg::TQ_W;

  logic [cbts_pkg::OSC_W-1:0]   osc_r;
  logic [cbts_pkg::RATE_W-1:0]  rate_r;
  logic [cbts_pkg::CAND_IW-1:0] cand_r;
  logic [cbts_pkg::OSC_W-1:0]   div_r;
  logic [cbts_pkg::OSC_W-1:0]   rem_r;
  logic [cbts_pkg::DSH_W-1:0]   dsh_r;
  logic [cbts_pkg::QUO_W-1:0]   quo_r;
  logic [cbts_pkg::STEP_W-1:0]  step_r;
  logic                         out_valid_r;
  logic                         out_found_r;
  logic [cbts_pkg::PRE_W-1:0]   out_pre_r;
  logic [cbts_pkg::PH1_W-1:0]   out_ph1_r;
  logic [cbts_pkg::PH2_W-1:0]   out_ph2_r;

  logic [PROD_W-1:0]            prod;
  logic                         ge;
  logic [cbts_pkg::QUO_W-1:0]   quo_m1;

  assign prod   = PROD_W'(rate_r) * PROD_W'(cbts_pkg::tq_of(cand_r));
  assign ge     = cbts_pkg::DSH_W'(rem_r) >= dsh_r;
  assign quo_m1 = quo_r - 7'd1;

  // Exact fit: zero remainder and a quotient of 1..64. A quotient of 128 or
  // more always leaves a nonzero remainder after the seven steps.
  assign sts.zero      = (rate_r == '0) || (osc_r == '0);
  assign sts.step_last = (step_r == '0);
  assign sts.fit       = (rem_r == '0) && (quo_r != '0) && (quo_r <= cbts_pkg::MAX_QUO);
  assign sts.cand_last = (cand_r == cbts_pkg::CAND_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_r <= cbts_pkg::OSC_RESET;
    end else if (cfg_wr_en) begin
      osc_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate_r <= in_bit_rate;
      cand_r <= '0;
    end else if (cmd.next_cand) begin
      cand_r <= cand_r + 3'd1;
    end
    if (cmd.calc_div) begin
      div_r <= {prod, 1'b0};
    end
    if (cmd.div_init) begin
      rem_r  <= osc_r;
      dsh_r  <= {div_r, {cbts_pkg::SHIFT_N{1'b0}}};
      quo_r  <= '0;
      step_r <= cbts_pkg::STEP_TOP;
    end else if (cmd.div_step) begin
      if (ge) rem_r <= rem_r - dsh_r[cbts_pkg::OSC_W-1:0];
      dsh_r  <= dsh_r >> 1;
      quo_r  <= {quo_r[cbts_pkg::QUO_W-2:0], ge};
      step_r <= step_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_ok || cmd.emit_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ok) begin
      out_found_r <= 1'b1;
      out_pre_r   <= quo_m1[cbts_pkg::PRE_W-1:0];
      out_ph1_r   <= cbts_pkg::ph1_of(cand_r);
      out_ph2_r   <= cbts_pkg::ph2_of(cand_r);
    end else if (cmd.emit_fail) begin
      out_found_r <= 1'b0;
      out_pre_r   <= '0;
      out_ph1_r   <= '0;
      out_ph2_r   <= '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_prescaler_byte = out_pre_r;
  assign out_phase_one_byte = out_ph1_r;
  assign out_phase_two_byte = out_ph2_r;

  `CBTS_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid_r, !out_valid_r)
  `CBTS_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid_r && !out_found_r,
                   out_pre_r == '0 && out_ph1_r == '0 && out_ph2_r == '0)
  `CBTS_ASSERT_IMP(a_found_mark, clk, rst_n, out_valid_r && out_found_r, out_ph1_r[7])

endmodule

FILE: rtl/core/can_bit_timing_search.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     start, accepted when !busy in_bit_rate
// result    out_valid, one-cycle      out_found, out_prescaler_byte,
//           strobe                    out_phase_one_byte, out_phase_two_byte
// config    cfg_wr_en                 cfg_wr_data (oscillator_hz)
//
// One request at a time. A zero rate or oscillator ends the search in the
// check state with a not-found result. Otherwise each candidate in turn
// goes through product, divider load, seven-step restoring divide and check,
// until one fits or all eight candidates have been tried.
// Synchronous active-low reset; oscillator register resets to 16 MHz.
// The receiver cannot stall; busy stays high until the strobe cycle.

module can_bit_timing_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [cbts_pkg::RATE_W-1:0]  in_bit_rate,
  input  logic                         cfg_wr_en,
  input  logic [cbts_pkg::OSC_W-1:0]   cfg_wr_data,
  output logic                         out_valid,
  output logic                         out_found,
  output logic [cbts_pkg::PRE_W-1:0]   out_prescaler_byte,
  output logic [cbts_pkg::PH1_W-1:0]   out_phase_one_byte,
  output logic [cbts_pkg::PH2_W-1:0]   out_phase_two_byte
);

  cbts_pkg::cmd_t cmd;
  cbts_pkg::sts_t sts;

  cbts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  cbts_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_bit_rate        (in_bit_rate),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_prescaler_byte (out_prescaler_byte),
    .out_phase_one_byte (out_phase_one_byte),
    .out_phase_two_byte (out_phase_two_byte)
  );

endmodule

FILE: bench/can_bit_timing_search_checker.sv
`timescale 1ns / 1ps

module can_bit_timing_search_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [cbts_pkg::RATE_W-1:0]  in_bit_rate,
  input  logic                         cfg_wr_en,
  input  logic [cbts_pkg::OSC_W-1:0]   cfg_wr_data,
  input  logic                         out_valid,
  input  logic                         out_found,
  input  logic [cbts_pkg::PRE_W-1:0]   out_prescaler_byte,
  input  logic [cbts_pkg::PH1_W-1:0]   out_phase_one_byte,
  input  logic [cbts_pkg::PH2_W-1:0]   out_phase_two_byte,
  output int                           mismatches,
  output int                           outstanding
);

  localparam logic [cbts_pkg::OSC_W-1:0] OSC_DEFAULT = 26'd16000000;
  localparam longint unsigned PRESCALE_MAX = 64;
  // Quanta per bit in search order, 5 bits each, first candidate in the top slot.
  localparam logic [39:0] QUANTA_SEQ =
    {5'd16, 5'd12, 5'd10, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5};

  typedef struct packed {
    logic                        found;
    logic [cbts_pkg::PRE_W-1:0]  prescaler;
    logic [cbts_pkg::PH1_W-1:0]  phase_one;
    logic [cbts_pkg::PH2_W-1:0]  phase_two;
  } timing_t;

  logic [cbts_pkg::OSC_W-1:0] osc_hz;
  timing_t                    expected_timings[$];

  function automatic timing_t predict_timing(input logic [cbts_pkg::RATE_W-1:0] rate,
                                             input logic [cbts_pkg::OSC_W-1:0] osc);
    timing_t          t;
    longint unsigned  divisor;
    longint unsigned  ratio;
    int unsigned      quanta;
    int unsigned      seg1;
    int unsigned      seg2;
    t = '0;
    if (rate == 0 || osc == 0) begin
      return t;
    end
    for (int k = 0; k < 8; k++) begin
      quanta = QUANTA_SEQ[39 - 5 * k -: 5];
      divisor = 64'd2 * rate * quanta;
      if (divisor > osc || (osc % divisor) != 0) begin
        continue;
      end
      ratio = osc / divisor;
      if (ratio > PRESCALE_MAX) begin
        continue;
      end
      seg1 = (quanta - 1) / 2;
      seg2 = quanta - 2 - seg1;
      // short bits: phase two is held at its minimum of two quanta
      if (seg2 < 2) begin
        seg2 = 2;
        seg1 = quanta - 4;
      end
      t.found     = 1'b1;
      t.prescaler = cbts_pkg::PRE_W'(ratio - 1);
      t.phase_one = 8'h80 | cbts_pkg::PH1_W'((seg1 - 1) << 3);
      t.phase_two = cbts_pkg::PH2_W'(seg2 - 1);
      return t;
    end
    return t;
  endfunction

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, got %0d", field, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    timing_t want;
    if (!rst_n) begin
      osc_hz = OSC_DEFAULT;
      expected_timings.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_timings.size() == 0) begin
          $error("result transaction with no request pending");
          mismatches++;
        end else begin
          want = expected_timings.pop_front();
          compare_field("found", 8'(want.found), 8'(out_found));
          compare_field("prescaler_byte", 8'(want.prescaler), 8'(out_prescaler_byte));
          compare_field("phase_one_byte", want.phase_one, out_phase_one_byte);
          compare_field("phase_two_byte", 8'(want.phase_two), 8'(out_phase_two_byte));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_timings.push_back(predict_timing(in_bit_rate, osc_hz));
      end
      if (cfg_wr_en === 1'b1) begin
        osc_hz = cfg_wr_data;
      end
    end
    outstanding <= expected_timings.size();
  end

endmodule

FILE: bench/can_bit_timing_search_tb.sv
`timescale 1ns / 1ps

module can_bit_timing_search_tb;

  localparam int unsigned RATE_MAX = 20'hFFFFF;
  localparam int unsigned OSC_MAX  = 26'h3FFFFFF;
  localparam int          PHASES   = 13;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [cbts_pkg::RATE_W-1:0]  in_bit_rate = '0;
  logic                         cfg_wr_en = 1'b0;
  logic [cbts_pkg::OSC_W-1:0]   cfg_wr_data = '0;
  logic                         out_valid;
  logic                         out_found;
  logic [cbts_pkg::PRE_W-1:0]   out_prescaler_byte;
  logic [cbts_pkg::PH1_W-1:0]   out_phase_one_byte;
  logic [cbts_pkg::PH2_W-1:0]   out_phase_two_byte;
  int                           mismatches;
  int                           outstanding;

  can_bit_timing_search i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_bit_rate        (in_bit_rate),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_prescaler_byte (out_prescaler_byte),
    .out_phase_one_byte (out_phase_one_byte),
    .out_phase_two_byte (out_phase_two_byte)
  );

  can_bit_timing_search_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_bit_rate        (in_bit_rate),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_prescaler_byte (out_prescaler_byte),
    .out_phase_one_byte (out_phase_one_byte),
    .out_phase_two_byte (out_phase_two_byte),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Product of small primes, so many quanta/prescaler pairs divide it.
  function automatic logic [cbts_pkg::OSC_W-1:0] smooth_osc();
    longint unsigned acc;
    int unsigned     factor;
    acc = 1;
    for (int i = 0; i < 40; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          factor = 2;
        end
        1: begin
          factor = 3;
        end
        2: begin
          factor = 5;
        end
        default: begin
          factor = 7;
        end
      endcase
      if (acc * factor <= OSC_MAX) begin
        acc = acc * factor;
      end
    end
    return cbts_pkg::OSC_W'(acc);
  endfunction

  function automatic logic [cbts_pkg::OSC_W-1:0] osc_for_phase(input int phase);
    case (phase)
      0: return '0;
      1: return 26'd1;
      2: return 26'h3FFFFFF;
      3: return 26'd8000000;
      4: return 26'd20000000;
      5: return 26'd24000000;
      6: return 26'd40000000;
      7: return 26'd64000000;
      8, 9, 10: return smooth_osc();
      11: return cbts_pkg::OSC_W'($urandom_range(0, OSC_MAX));
      default: return 26'd16000000;
    endcase
  endfunction

  // Mostly rates that divide the oscillator for some quanta/prescaler pair,
  // plus near misses, edge values and raw noise.
  function automatic logic [cbts_pkg::RATE_W-1:0] pick_rate(
      input logic [cbts_pkg::OSC_W-1:0] osc);
    int unsigned quanta;
    int unsigned divisor;
    int unsigned quotient;
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      case ($urandom_range(0, 7))
        0: quanta = 16;
        1: quanta = 12;
        2: quanta = 10;
        3: quanta = 9;
        4: quanta = 8;
        5: quanta = 7;
        6: quanta = 6;
        default: quanta = 5;
      endcase
      divisor = 2 * quanta * $urandom_range(1, 66);
      if (osc != 0 && (osc % divisor) == 0 && (osc / divisor) <= RATE_MAX) begin
        quotient = osc / divisor;
        if (roll == 6) begin
          return cbts_pkg::RATE_W'(quotient + $urandom_range(0, 2) - 1);
        end
        return cbts_pkg::RATE_W'(quotient);
      end
    end
    if (roll == 9) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return 20'd1;
        2: return 20'hFFFFF;
        3: return 20'd1000000;
        default: return cbts_pkg::RATE_W'($urandom_range(1, 2000));
      endcase
    end
    return cbts_pkg::RATE_W'($urandom);
  endfunction

  task automatic send_rate(input logic [cbts_pkg::RATE_W-1:0] rate, input bit may_idle);
    start <= 1'b1;
    in_bit_rate <= rate;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) begin
      @(posedge clk);
    end
  endtask

  task automatic set_osc(input logic [cbts_pkg::OSC_W-1:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [cbts_pkg::OSC_W-1:0]  osc;
    logic [cbts_pkg::RATE_W-1:0] directed_rates[$];
    bit                          idle_on;
    int                          count;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset oscillator: zero rate, rate above range, divisor above oscillator,
    // no fit, and fits on long and short bit times.
    directed_rates = '{20'd0, 20'd1, 20'd2, 20'd1000000, 20'd500000, 20'd250000,
                       20'd125000, 20'd100000, 20'd50000, 20'd20000, 20'd10000,
                       20'd320000, 20'd15625, 20'd333333, 20'd524288, 20'hFFFFF};
    foreach (directed_rates[i]) begin
      send_rate(directed_rates[i], 1'b0);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      osc = osc_for_phase(phase);
      set_osc(osc);
      count = (osc < 2) ? 30 : 130;
      idle_on = 1'b1;
      for (int i = 0; i < count; i++) begin
        if (i % 40 == 0) begin
          idle_on = (phase != PHASES - 1) && ($urandom_range(0, 2) != 0);
        end
        send_rate(pick_rate(osc), idle_on);
      end
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: can_bit_timing_search.f
+incdir+rtl/core
rtl/core/cbts_pkg.sv
rtl/core/cbts_ctrl.sv
rtl/core/cbts_datapath.sv
rtl/core/can_bit_timing_search.sv
bench/can_bit_timing_search_checker.sv
bench/can_bit_timing_search_tb.sv
